>>> rtl/frame_arena_fence_lifecycle_defines.svh
// Assertion macros shared by the frame arena checker.
`ifndef FRAME_ARENA_FENCE_LIFECYCLE_DEFINES_SVH
`define FRAME_ARENA_FENCE_LIFECYCLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fal_pkg.sv
// Types and constants shared by the frame arena fence lifecycle block.
`timescale 1ns / 1ps

package fal_pkg;

  typedef enum logic [2:0] {
    CMD_BEGIN   = 3'd0,
    CMD_SUBMIT  = 3'd1,
    CMD_UPLOAD  = 3'd2,
    CMD_DESC    = 3'd3,
    CMD_DISCARD = 3'd4,
    CMD_RETIRE  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ARG     = 2'd1,
    ST_STATE   = 2'd2,
    ST_UNAVAIL = 2'd3
  } status_t;

  localparam logic REG_UPLOAD_CAP = 1'b0;
  localparam logic REG_DESC_CAP   = 1'b1;

  localparam logic [31:0] UPLOAD_CAP_RESET = 32'd1048576;
  localparam logic [31:0] DESC_CAP_RESET   = 32'd4096;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] fence;
    logic [31:0] size;
    logic [31:0] align;
  } item_t;

  typedef struct packed {
    logic        active;
    logic [63:0] awaited;
    logic [63:0] last_submitted;
    logic [63:0] generation;
    logic [31:0] up_cursor;
    logic [31:0] up_high;
    logic [31:0] desc_cursor;
    logic [31:0] desc_high;
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic        retired;
    logic        frame_active;
    logic [63:0] generation_count;
    logic [63:0] pending_fence;
    logic [63:0] wait_fence;
    logic [31:0] upload_level;
    logic [31:0] upload_peak;
    logic [31:0] descriptor_level;
    logic [31:0] descriptor_peak;
  } result_t;

endpackage

>>> rtl/fal_core.sv
// Command decode, arena bump allocation and fence lifecycle next-state logic.
`timescale 1ns / 1ps

module fal_core
  import fal_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  item_t       item,
  input  state_t      st,
  input  logic [31:0] upload_cap,
  input  logic [31:0] desc_cap,
  output state_t      st_nxt,
  output result_t     res
);

  localparam logic [63:0] OFFSET_MAX =
    (OFFSET_BITS >= 64) ? {64{1'b1}} : ((64'd1 << OFFSET_BITS) - 64'd1);

  typedef struct packed {
    status_t     status;
    logic [31:0] where;
    logic [31:0] cursor;
    logic [31:0] high;
  } take_t;

  function automatic take_t arena_take(input logic [31:0] cursor, input logic [31:0] high,
                                       input logic [31:0] cap, input logic [31:0] size,
                                       input logic [31:0] align);
    logic [31:0] mask;
    logic [63:0] limit;
    logic [32:0] start;
    logic [31:0] bumped;
    take_t       t;
    mask   = align - 32'd1;
    limit  = OFFSET_MAX - {32'd0, mask};
    start  = ({1'b0, cursor} + {1'b0, mask}) & ~{1'b0, mask};
    bumped = start[31:0] + size;
    t.status = ST_OK;
    t.where  = start[31:0];
    t.cursor = cursor;
    t.high   = high;
    priority if (size == 32'd0) begin
      t.status = ST_ARG;
    end else if (align == 32'd0 || (align & mask) != 32'd0) begin
      t.status = ST_ARG;
    end else if ({32'd0, cursor} > limit) begin
      t.status = ST_UNAVAIL;
    end else if (start > {1'b0, cap} || size > (cap - start[31:0])) begin
      t.status = ST_UNAVAIL;
    end else begin
      t.cursor = bumped;
      t.high   = (bumped > high) ? bumped : high;
    end
    return t;
  endfunction

  take_t   up_take;
  take_t   desc_take;
  status_t status;
  logic [31:0] where;
  logic    released;

  assign up_take   = arena_take(st.up_cursor, st.up_high, upload_cap, item.size, item.align);
  assign desc_take = arena_take(st.desc_cursor, st.desc_high, desc_cap, item.size, 32'd1);

  always_comb begin
    st_nxt   = st;
    status   = ST_OK;
    where    = 32'd0;
    released = 1'b0;
    unique case (item.cmd)
      CMD_BEGIN, CMD_RETIRE: begin
        priority if (st.active) begin
          status = ST_STATE;
        end else if (item.cmd == CMD_BEGIN && st.generation == {64{1'b1}}) begin
          status = ST_UNAVAIL;
        end else if (st.awaited != 64'd0 && item.fence < st.awaited) begin
          status = ST_STATE;
        end else begin
          if (st.awaited != 64'd0) begin
            st_nxt.awaited     = 64'd0;
            st_nxt.up_cursor   = 32'd0;
            st_nxt.desc_cursor = 32'd0;
            released           = 1'b1;
          end
          if (item.cmd == CMD_BEGIN) begin
            st_nxt.up_cursor   = 32'd0;
            st_nxt.desc_cursor = 32'd0;
            st_nxt.generation  = st.generation + 64'd1;
            st_nxt.active      = 1'b1;
          end
        end
      end
      CMD_SUBMIT: begin
        priority if (!st.active) begin
          status = ST_STATE;
        end else if (item.fence == 64'd0 || item.fence <= st.last_submitted) begin
          status = ST_ARG;
        end else begin
          st_nxt.awaited        = item.fence;
          st_nxt.last_submitted = item.fence;
          st_nxt.active         = 1'b0;
        end
      end
      CMD_UPLOAD: begin
        if (!st.active) begin
          status = ST_STATE;
        end else begin
          status           = up_take.status;
          where            = up_take.where;
          st_nxt.up_cursor = up_take.cursor;
          st_nxt.up_high   = up_take.high;
        end
      end
      CMD_DESC: begin
        if (!st.active) begin
          status = ST_STATE;
        end else begin
          status             = desc_take.status;
          where              = desc_take.where;
          st_nxt.desc_cursor = desc_take.cursor;
          st_nxt.desc_high   = desc_take.high;
        end
      end
      CMD_DISCARD: begin
        st_nxt.active      = 1'b0;
        st_nxt.awaited     = 64'd0;
        st_nxt.up_cursor   = 32'd0;
        st_nxt.desc_cursor = 32'd0;
      end
      default: begin
        status = ST_ARG;
      end
    endcase
  end

  always_comb begin
    res.status           = status;
    res.offset           = (status == ST_OK) ? where : 32'd0;
    res.retired          = released;
    res.frame_active     = st_nxt.active;
    res.generation_count = st_nxt.generation;
    res.pending_fence    = st_nxt.awaited;
    res.wait_fence       = (st_nxt.awaited != 64'd0 && item.fence < st_nxt.awaited) ?
                           st_nxt.awaited : 64'd0;
    res.upload_level     = st_nxt.up_cursor;
    res.upload_peak      = st_nxt.up_high;
    res.descriptor_level = st_nxt.desc_cursor;
    res.descriptor_peak  = st_nxt.desc_high;
  end

endmodule

>>> rtl/frame_arena_fence_lifecycle.sv
// Top level of the frame arena allocator with fence lifecycle.
// An accepted command waits in the input register; its result is registered in the
// result register, which drives the outputs. The state update is one registered pass.
// Throughput: one command per cycle while out_ready does not hold the result register.
// The input register and the result register let a new command enter while a result waits.
// Reset (synchronous, rst_n low) clears all frame state and loads the default capacities.
`timescale 1ns / 1ps

module frame_arena_fence_lifecycle
  import fal_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_fence_value,
  input  logic [31:0] in_alloc_size,
  input  logic [31:0] in_alignment,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_offset,
  output logic        out_retired,
  output logic        out_frame_active,
  output logic [63:0] out_generation_count,
  output logic [63:0] out_pending_fence,
  output logic [63:0] out_wait_fence,
  output logic [31:0] out_upload_level,
  output logic [31:0] out_upload_peak,
  output logic [31:0] out_descriptor_level,
  output logic [31:0] out_descriptor_peak
);

  logic [31:0] upload_cap_r;
  logic [31:0] desc_cap_r;
  item_t       item_r;
  logic        item_valid_r;
  state_t      state_r;
  state_t      state_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        res_valid_r;
  logic        advance;

  assign advance  = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upload_cap_r <= UPLOAD_CAP_RESET;
      desc_cap_r   <= DESC_CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPLOAD_CAP: upload_cap_r <= cfg_wdata;
        REG_DESC_CAP:   desc_cap_r   <= cfg_wdata;
        default:        upload_cap_r <= upload_cap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.cmd   <= in_cmd;
      item_r.fence <= in_fence_value;
      item_r.size  <= in_alloc_size;
      item_r.align <= in_alignment;
    end
  end

  fal_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .item      (item_r),
    .st        (state_r),
    .upload_cap(upload_cap_r),
    .desc_cap  (desc_cap_r),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_status           = res_r.status;
  assign out_offset           = res_r.offset;
  assign out_retired          = res_r.retired;
  assign out_frame_active     = res_r.frame_active;
  assign out_generation_count = res_r.generation_count;
  assign out_pending_fence    = res_r.pending_fence;
  assign out_wait_fence       = res_r.wait_fence;
  assign out_upload_level     = res_r.upload_level;
  assign out_upload_peak      = res_r.upload_peak;
  assign out_descriptor_level = res_r.descriptor_level;
  assign out_descriptor_peak  = res_r.descriptor_peak;

endmodule

>>> rtl/fal_checker.sv
// Port-level assertion checker for the frame arena block and its bind.
`timescale 1ns / 1ps
`include "frame_arena_fence_lifecycle_defines.svh"

module fal_checker
  import fal_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_offset,
  input logic        out_frame_active,
  input logic [63:0] out_pending_fence,
  input logic [31:0] out_upload_level,
  input logic [31:0] out_upload_peak,
  input logic [31:0] out_descriptor_level,
  input logic [31:0] out_descriptor_peak
);

  `FAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_offset), "result item changed while stalled")
  `FAL_ASSERT_NOW(a_fail_offset, clk, rst_n, out_valid && out_status != ST_OK, out_offset == 32'd0, "failed item reports a nonzero offset")
  `FAL_ASSERT_NOW(a_upload_peak, clk, rst_n, out_valid, out_upload_level <= out_upload_peak, "upload cursor above its peak")
  `FAL_ASSERT_NOW(a_desc_peak, clk, rst_n, out_valid, out_descriptor_level <= out_descriptor_peak, "descriptor cursor above its peak")
  `FAL_ASSERT_NOW(a_active_no_fence, clk, rst_n, out_valid && out_frame_active, out_pending_fence == 64'd0, "active frame still awaits a fence")

endmodule

bind frame_arena_fence_lifecycle fal_checker u_fal_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_offset          (out_offset),
  .out_frame_active    (out_frame_active),
  .out_pending_fence   (out_pending_fence),
  .out_upload_level    (out_upload_level),
  .out_upload_peak     (out_upload_peak),
  .out_descriptor_level(out_descriptor_level),
  .out_descriptor_peak (out_descriptor_peak)
);
